@@ hdl/assert_macros.svh @@
// Assertion macros shared by the smoother RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WRPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WRPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/wrps_pkg.sv @@
// Package for the weighted rank profile smoother: payload structs, opcodes,
// sequencer states and divider request/response types. No dependencies.
package wrps_pkg;

  localparam int MAX_BINS_DEF        = 4096;
  localparam int MAX_HALF_WINDOW_DEF = 16;

  localparam int SUM_W     = 40;
  localparam int CNT_W     = 24;
  localparam int IDX_OUT_W = 12;
  localparam int HW_CFG_W  = 5;
  localparam int WEIGHT_W  = 17;
  localparam int WEIGHT_ONE = 65536;

  localparam int DIVD_W    = 64;
  localparam int DIVR_W    = 24;
  localparam int DIV_CNT_W = 7;
  localparam logic [DIV_CNT_W-1:0] MEAN_ITERS = 7'd40;
  localparam logic [DIV_CNT_W-1:0] AVG_ITERS  = 7'd64;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EMIT  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [SUM_W-1:0] bin_sum;
    logic [CNT_W-1:0] bin_count;
  } in_t;

  typedef struct packed {
    logic [SUM_W-1:0]     smoothed_sum;
    logic [IDX_OUT_W-1:0] bin_index;
    logic                 last_bin;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CTR_RD,
    ST_CTR_WT,
    ST_WIN_RD,
    ST_WIN_DIV,
    ST_DIV_WAIT,
    ST_INSERT,
    ST_WSUM_MUL,
    ST_WSUM_ACC,
    ST_AVG_DIV,
    ST_AVG_WAIT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
    logic [DIVD_W-1:0]    dividend;
    logic [DIVR_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hdl/wrps_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on wrps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wrps_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wrps_pkg::div_req_t req,
  output wrps_pkg::div_rsp_t rsp
);
  import wrps_pkg::*;

  logic [DIVR_W-1:0]    rem_r;
  logic [DIVR_W-1:0]    dvs_r;
  logic [DIVD_W-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIVR_W:0]      trial;

  assign trial = {rem_r, quo_r[DIVD_W-1]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
      cnt_r <= req.iters;
    end else if (busy_r) begin
      // keep the trial difference when it does not go negative
      if (!trial[DIVR_W]) begin
        rem_r <= trial[DIVR_W-1:0];
        quo_r <= {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DIVR_W-2:0], quo_r[DIVD_W-1]};
        quo_r <= {quo_r[DIVD_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  `WRPS_ASSERT_IMPL(a_start_idle, req.start, !busy_r, "divider started while busy")
  `WRPS_ASSERT_NEXT(a_start_busy, req.start, busy_r, "divider did not go busy")
  `WRPS_ASSERT_IMPL(a_done_after, done_r, $past(busy_r), "done without a run")

endmodule

@@ hdl/weighted_rank_profile_smoother.sv @@
// Weighted rank profile smoother; depends on wrps_pkg, wrps_div and assert_macros.svh.
// Clear, load, ignored and empty-profile emits stay in ST_IDLE and are taken back to back.
// An emit over n = 2m-1 bins reads the center count, then for each bin reads it and divides
// sum by count (not for a zero-count bin) and inserts the mean in order; then it takes one
// weighted step per rank, a final divide and the product, and out_valid rises back in idle.
// Synchronous active-low reset empties the profile and sets half_window to 1.
`include "assert_macros.svh"

module weighted_rank_profile_smoother #(
  parameter int MAX_BINS        = wrps_pkg::MAX_BINS_DEF,
  parameter int MAX_HALF_WINDOW = wrps_pkg::MAX_HALF_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wrps_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wrps_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wrps_pkg::HW_CFG_W-1:0] cfg_data
);
  import wrps_pkg::*;

  localparam int IDX_W   = $clog2(MAX_BINS);
  localparam int LEN_W   = $clog2(MAX_BINS + 1);
  localparam int WIN_CAP = 2 * MAX_HALF_WINDOW - 1;
  localparam int WC_W    = $clog2(2 * MAX_HALF_WINDOW + 1);
  localparam int HW_W    = $clog2(MAX_HALF_WINDOW + 1);
  localparam int OFF_W   = (MAX_HALF_WINDOW > 1) ? $clog2(MAX_HALF_WINDOW) : 1;
  localparam int POS_W   = ((IDX_W > WC_W) ? IDX_W : WC_W) + 2;
  localparam int DEN_W   = WEIGHT_W + WC_W;
  localparam int PROD_W  = SUM_W + WEIGHT_W;
  localparam int HALF_W  = SUM_W / 2;

  // Profile store: {sum, count} per bin, one write and one read per cycle.
  logic [SUM_W+CNT_W-1:0] mem [MAX_BINS];
  logic [SUM_W+CNT_W-1:0] rd_data_r;
  logic [IDX_W-1:0]       rd_addr;

  // Rank weights floor(65536/(off+1)), worked out at elaboration.
  logic [WEIGHT_W-1:0] weight_tab [MAX_HALF_WINDOW];
  for (genvar g = 0; g < MAX_HALF_WINDOW; g++) begin : g_weight
    localparam int W = WEIGHT_ONE / (g + 1);
    assign weight_tab[g] = WEIGHT_W'(W);
  end

  state_t state_r, state_nxt;

  logic [HW_CFG_W-1:0] half_window_r;
  logic [LEN_W-1:0]    profile_length_r;
  logic [IDX_W-1:0]    emit_index_r;
  logic [IDX_W-1:0]    idx_r;
  logic                last_r;
  logic [WC_W-1:0]     n_r;
  logic [WC_W-1:0]     mm1_r;
  logic [WC_W-1:0]     p_r;
  logic signed [POS_W-1:0] pos_r;
  logic [CNT_W-1:0]    ccount_r;
  logic [SUM_W-1:0]    mean_r;
  logic [SUM_W-1:0]    win_r [WIN_CAP];
  logic [PROD_W-1:0]   prod_r;
  logic [DIVD_W-1:0]   num_r;
  logic [DEN_W-1:0]    den_r;
  logic [SUM_W-1:0]    avg_r;
  logic [DIVD_W-1:0]   prod64_r;
  logic                out_valid_r;
  out_t                out_data_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  wrps_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Emit setup: wrap the emit index and clamp the half window.
  logic [IDX_W-1:0] idx_eff;
  logic [HW_W-1:0]  m_eff;
  logic             in_acc;

  assign in_acc = in_valid && in_ready;

  always_comb begin
    if (LEN_W'(emit_index_r) >= profile_length_r) idx_eff = '0;
    else idx_eff = emit_index_r;
    if (half_window_r == '0) m_eff = HW_W'(1);
    else if (int'(half_window_r) > MAX_HALF_WINDOW) m_eff = HW_W'(MAX_HALF_WINDOW);
    else m_eff = HW_W'(half_window_r);
  end

  // Window position: mirror negatives, clamp past the end.
  logic [POS_W-1:0] pos_abs;
  logic [IDX_W-1:0] win_addr;

  always_comb begin
    pos_abs = pos_r[POS_W-1] ? POS_W'(-pos_r) : POS_W'(pos_r);
    if (pos_abs >= POS_W'(profile_length_r)) win_addr = IDX_W'(profile_length_r - LEN_W'(1));
    else win_addr = pos_abs[IDX_W-1:0];
  end

  // Rank offset from the window center.
  logic [WC_W-1:0] off;
  assign off = (p_r >= mm1_r) ? (p_r - mm1_r) : (mm1_r - p_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.operation == OP_EMIT && profile_length_r != '0)
          state_nxt = ST_CTR_RD;
      end
      ST_CTR_RD:  state_nxt = ST_CTR_WT;
      ST_CTR_WT:  state_nxt = ST_WIN_DIV;
      ST_WIN_RD:  state_nxt = ST_WIN_DIV;
      ST_WIN_DIV: begin
        if (rd_data_r[CNT_W-1:0] == '0) state_nxt = ST_INSERT;
        else state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: if (div_rsp.done) state_nxt = ST_INSERT;
      ST_INSERT: begin
        if (p_r == n_r - WC_W'(1)) state_nxt = ST_WSUM_MUL;
        else state_nxt = ST_WIN_RD;
      end
      ST_WSUM_MUL: state_nxt = ST_WSUM_ACC;
      ST_WSUM_ACC: begin
        if (p_r == n_r - WC_W'(1)) state_nxt = ST_AVG_DIV;
        else state_nxt = ST_WSUM_MUL;
      end
      ST_AVG_DIV:  state_nxt = ST_AVG_WAIT;
      ST_AVG_WAIT: if (div_rsp.done) state_nxt = ST_MUL_LO;
      ST_MUL_LO:   state_nxt = ST_MUL_HI;
      ST_MUL_HI:   state_nxt = ST_DONE;
      ST_DONE:     if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, memory address, divider launch.
  always_comb begin
    in_ready         = 1'b0;
    rd_addr          = win_addr;
    div_req.start    = 1'b0;
    div_req.iters    = MEAN_ITERS;
    div_req.dividend = {rd_data_r[SUM_W+CNT_W-1:CNT_W], {(DIVD_W-SUM_W){1'b0}}};
    div_req.divisor  = DIVR_W'(rd_data_r[CNT_W-1:0]);
    unique case (state_r)
      ST_IDLE:    in_ready = 1'b1;
      ST_CTR_RD:  rd_addr = idx_r;
      ST_WIN_DIV: div_req.start = (rd_data_r[CNT_W-1:0] != '0);
      ST_AVG_DIV: begin
        div_req.start    = 1'b1;
        div_req.iters    = AVG_ITERS;
        div_req.dividend = num_r;
        div_req.divisor  = DIVR_W'(den_r);
      end
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  // Profile store.
  always_ff @(posedge clk) begin
    if (in_acc && in_data.operation == OP_LOAD && int'(profile_length_r) < MAX_BINS)
      mem[profile_length_r[IDX_W-1:0]] <= {in_data.bin_sum, in_data.bin_count};
    rd_data_r <= mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      half_window_r    <= HW_CFG_W'(1);
      profile_length_r <= '0;
      emit_index_r     <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) half_window_r <= cfg_data;
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (in_acc) begin
        case (in_data.operation)
          OP_CLEAR: begin
            profile_length_r <= '0;
            emit_index_r     <= '0;
          end
          OP_LOAD: begin
            if (int'(profile_length_r) < MAX_BINS)
              profile_length_r <= profile_length_r + LEN_W'(1);
          end
          OP_EMIT: begin
            if (profile_length_r != '0) begin
              // advance, wrapping after the last bin
              if (LEN_W'(idx_eff) + LEN_W'(1) >= profile_length_r) emit_index_r <= '0;
              else emit_index_r <= idx_eff + IDX_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath, stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        idx_r  <= idx_eff;
        last_r <= (LEN_W'(idx_eff) + LEN_W'(1) == profile_length_r);
        n_r    <= WC_W'(m_eff) + WC_W'(m_eff) - WC_W'(1);
        mm1_r  <= WC_W'(m_eff) - WC_W'(1);
        p_r    <= '0;
        pos_r  <= $signed(POS_W'(idx_eff)) - $signed(POS_W'(m_eff) - POS_W'(1));
        num_r  <= '0;
        den_r  <= '0;
        // fill with the top value so unfilled slots sort last
        for (int k = 0; k < WIN_CAP; k++) win_r[k] <= '1;
      end
      ST_CTR_WT: ccount_r <= rd_data_r[CNT_W-1:0];
      ST_WIN_DIV: mean_r <= '0;
      ST_DIV_WAIT: if (div_rsp.done) mean_r <= div_rsp.quotient[SUM_W-1:0];
      ST_INSERT: begin
        // each slot looks only at itself and its left neighbor
        if (win_r[0] > mean_r) win_r[0] <= mean_r;
        for (int k = 1; k < WIN_CAP; k++) begin
          if (win_r[k] > mean_r) begin
            if (win_r[k-1] <= mean_r) win_r[k] <= mean_r;
            else win_r[k] <= win_r[k-1];
          end
        end
        pos_r <= pos_r + POS_W'(1);
        if (p_r == n_r - WC_W'(1)) p_r <= '0;
        else p_r <= p_r + WC_W'(1);
      end
      ST_WSUM_MUL: begin
        prod_r <= win_r[0] * weight_tab[off[OFF_W-1:0]];
        den_r  <= den_r + DEN_W'(weight_tab[off[OFF_W-1:0]]);
        // shift the sorted window toward slot 0
        for (int k = 0; k < WIN_CAP - 1; k++) win_r[k] <= win_r[k+1];
        win_r[WIN_CAP-1] <= '1;
      end
      ST_WSUM_ACC: begin
        num_r <= num_r + DIVD_W'(prod_r);
        p_r   <= p_r + WC_W'(1);
      end
      ST_AVG_WAIT: if (div_rsp.done) avg_r <= div_rsp.quotient[SUM_W-1:0];
      ST_MUL_LO: prod64_r <= DIVD_W'(avg_r[HALF_W-1:0] * ccount_r);
      ST_MUL_HI: prod64_r <= prod64_r + (DIVD_W'(avg_r[SUM_W-1:HALF_W] * ccount_r) << HALF_W);
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          // saturate to the field width
          out_data_r.smoothed_sum <= (|prod64_r[DIVD_W-1:SUM_W]) ? '1 : prod64_r[SUM_W-1:0];
          out_data_r.bin_index    <= IDX_OUT_W'(idx_r);
          out_data_r.last_bin     <= last_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WRPS_ASSERT_IMPL(a_emit_idx, 1'b1,
    (LEN_W'(emit_index_r) < profile_length_r) || (emit_index_r == '0),
    "emit index beyond profile")
  `WRPS_ASSERT_IMPL(a_out_from_done, $rose(out_valid_r), $past(state_r == ST_DONE),
    "result raised outside done state")
  `WRPS_ASSERT_IMPL(a_rank_bound, state_r == ST_INSERT || state_r == ST_WSUM_ACC,
    p_r < n_r, "rank counter past window")
  `WRPS_ASSERT_NEXT(a_emit_busy, state_r == ST_CTR_RD, !in_ready,
    "input taken during emit")

endmodule
